[rtl/sboa_pkg.sv]
// ----------------------------------------------------------------------------
// sboa_pkg
// Shared types, codes and helpers of the slab bitmap object allocator.
// ----------------------------------------------------------------------------
package sboa_pkg;

	localparam int SLOT_COUNT  = 16;
	localparam int SLOT_W      = 4;
	localparam int MAX_OBJECTS = 128;
	localparam int IDX_W       = 7;
	localparam int CNT_W       = 8;
	localparam int STAMP_W     = 32;
	localparam int SIZE_W      = 13;
	localparam int BYTES_W     = 16;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_LARGE     = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_UNUSED    = 3'd4;
	localparam logic [2:0] ST_BAD_INDEX = 3'd5;
	localparam logic [2:0] ST_DOUBLE    = 3'd6;

	// slab lists
	localparam logic [1:0] LIST_FREE    = 2'd0;
	localparam logic [1:0] LIST_PARTIAL = 2'd1;
	localparam logic [1:0] LIST_FULL    = 2'd2;

	// commands
	localparam logic CMD_ALLOC = 1'b0;

	// size classes
	localparam logic [1:0] CLASS_SMALL = 2'd0;
	localparam logic [1:0] CLASS_MID   = 2'd1;
	localparam logic [1:0] CLASS_LARGE = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_SIZE_SMALL  = 3'd0;
	localparam logic [2:0] REG_SIZE_MID    = 3'd1;
	localparam logic [2:0] REG_SIZE_LARGE  = 3'd2;
	localparam logic [2:0] REG_COUNT_SMALL = 3'd3;
	localparam logic [2:0] REG_COUNT_MID   = 3'd4;
	localparam logic [2:0] REG_COUNT_LARGE = 3'd5;

	typedef struct packed {
		logic                command;
		logic [BYTES_W-1:0]  request_bytes;
		logic [SLOT_W-1:0]   slot_in;
		logic [IDX_W-1:0]    index_in;
	} req_word_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [SLOT_W-1:0]   slot_out;
		logic [IDX_W-1:0]    index_out;
		logic [1:0]          class_out;
	} rsp_word_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_PICK,
		S_FIND,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic decode;
		logic scan_step;
		logic pick;
		logic find;
		logic load_rsp;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_last;
		logic pick_fail;
	} dp_sts_t;

	// objects per slab from the count register
	function automatic logic [CNT_W-1:0] objects_for(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n == '0) r = CNT_W'(1);
		else if (n > CNT_W'(MAX_OBJECTS)) r = CNT_W'(MAX_OBJECTS);
		return r;
	endfunction

	// lowest clear bit below tot; MSB flags a hit
	function automatic logic [IDX_W:0] lowest_free(input logic [MAX_OBJECTS-1:0] bits,
			input logic [CNT_W-1:0] tot);
		logic [IDX_W:0] r;
		r = '0;
		for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
			if (!bits[i] && (CNT_W'(i) < tot)) r = {1'b1, IDX_W'(i)};
		end
		return r;
	endfunction

endpackage

[rtl/sboa_ctrl.sv]
// ----------------------------------------------------------------------------
// sboa_ctrl
// Sequencer of the allocator: accept, decode, slot scan, pick, bit search,
// and handoff to the response register.
// ----------------------------------------------------------------------------
module sboa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  sboa_pkg::dp_sts_t sts,
	output sboa_pkg::dp_cmd_t cmd
);

	sboa_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;
	logic             rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sboa_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_rsp) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sboa_pkg::S_IDLE: begin
				if (req_valid) state_d = sboa_pkg::S_DECODE;
			end
			sboa_pkg::S_DECODE: begin
				state_d = sts.need_scan ? sboa_pkg::S_SCAN : sboa_pkg::S_DONE;
			end
			sboa_pkg::S_SCAN: begin
				if (sts.scan_last) state_d = sboa_pkg::S_PICK;
			end
			sboa_pkg::S_PICK: begin
				state_d = sts.pick_fail ? sboa_pkg::S_DONE : sboa_pkg::S_FIND;
			end
			sboa_pkg::S_FIND: begin
				state_d = sboa_pkg::S_DONE;
			end
			sboa_pkg::S_DONE: begin
				if (rsp_free) state_d = sboa_pkg::S_IDLE;
			end
			default: state_d = sboa_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			sboa_pkg::S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = req_valid;
			end
			sboa_pkg::S_DECODE: cmd.decode    = 1'b1;
			sboa_pkg::S_SCAN:   cmd.scan_step = 1'b1;
			sboa_pkg::S_PICK:   cmd.pick      = 1'b1;
			sboa_pkg::S_FIND:   cmd.find      = 1'b1;
			sboa_pkg::S_DONE:   cmd.load_rsp  = rsp_free;
			default: cmd = '0;
		endcase
	end

endmodule

[rtl/sboa_dp.sv]
// ----------------------------------------------------------------------------
// sboa_dp
// Datapath: class registers, slot tables, bitmaps, recency scan, bit search
// and the result and response registers.
// ----------------------------------------------------------------------------
module sboa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [2:0]                        cfg_index,
	input  logic [sboa_pkg::SIZE_W-1:0]       cfg_data,
	input  sboa_pkg::req_word_t               req_data,
	output sboa_pkg::rsp_word_t               rsp_data,
	input  sboa_pkg::dp_cmd_t                 cmd,
	output sboa_pkg::dp_sts_t                 sts
);

	localparam int SC = sboa_pkg::SLOT_COUNT;
	localparam int SW = sboa_pkg::SLOT_W;
	localparam int CW = sboa_pkg::CNT_W;
	localparam int TW = sboa_pkg::STAMP_W;

	// configuration
	logic [sboa_pkg::SIZE_W-1:0] size_q  [3];
	logic [CW-1:0]               count_q [3];

	// slot tables
	logic [SC-1:0]                    in_use_q;
	logic [1:0]                       class_q  [SC];
	logic [1:0]                       list_q   [SC];
	logic [TW-1:0]                    stamp_q  [SC];
	logic [CW-1:0]                    fcnt_q   [SC];
	logic [CW-1:0]                    total_q  [SC];
	logic [sboa_pkg::MAX_OBJECTS-1:0] bitmap_q [SC];
	logic [TW-1:0]                    counter_q;

	// request and working registers
	sboa_pkg::req_word_t req_q;
	sboa_pkg::rsp_word_t res_q, rsp_q;
	logic [1:0]          cls_q;
	logic [SW-1:0]       cnt_q;
	logic                pf_q, ff_q, uf_q;
	logic [SW-1:0]       ps_q, fs_q, us_q, sel_q;
	logic [TW-1:0]       pa_q, fa_q;

	// class selection
	logic        class_ok;
	logic [1:0]  class_sel;
	always_comb begin
		class_ok  = 1'b1;
		class_sel = sboa_pkg::CLASS_SMALL;
		if ({3'b0, size_q[0]} >= req_q.request_bytes) class_sel = sboa_pkg::CLASS_SMALL;
		else if ({3'b0, size_q[1]} >= req_q.request_bytes) class_sel = sboa_pkg::CLASS_MID;
		else if ({3'b0, size_q[2]} >= req_q.request_bytes) class_sel = sboa_pkg::CLASS_LARGE;
		else class_ok = 1'b0;
	end

	logic alloc_ok;
	assign alloc_ok = (req_q.command == sboa_pkg::CMD_ALLOC)
		&& (req_q.request_bytes != '0) && class_ok;

	// free-side lookups
	logic [SW-1:0] fslot;
	logic [sboa_pkg::IDX_W-1:0] fidx;
	logic [CW-1:0] fcnt_inc;
	logic          free_ok;
	assign fslot    = req_q.slot_in;
	assign fidx     = req_q.index_in;
	assign fcnt_inc = (fcnt_q[fslot] < total_q[fslot]) ? fcnt_q[fslot] + CW'(1) : fcnt_q[fslot];
	assign free_ok  = (req_q.command != sboa_pkg::CMD_ALLOC) && in_use_q[fslot]
		&& ({1'b0, fidx} < total_q[fslot]) && bitmap_q[fslot][fidx];

	// decode result: alloc size failures and every free outcome
	sboa_pkg::rsp_word_t dec_res;
	always_comb begin
		dec_res = '0;
		if (req_q.command == sboa_pkg::CMD_ALLOC) begin
			if (req_q.request_bytes == '0) dec_res.status = sboa_pkg::ST_ZERO;
			else if (!class_ok) dec_res.status = sboa_pkg::ST_LARGE;
		end else begin
			dec_res.slot_out  = fslot;
			dec_res.index_out = fidx;
			if (!in_use_q[fslot]) begin
				dec_res.status = sboa_pkg::ST_UNUSED;
			end else begin
				dec_res.class_out = class_q[fslot];
				if ({1'b0, fidx} >= total_q[fslot]) dec_res.status = sboa_pkg::ST_BAD_INDEX;
				else if (!bitmap_q[fslot][fidx]) dec_res.status = sboa_pkg::ST_DOUBLE;
				else dec_res.status = sboa_pkg::ST_OK;
			end
		end
	end

	// scan step
	logic [TW-1:0] age;
	logic          scan_hit;
	assign age      = counter_q - stamp_q[cnt_q];
	assign scan_hit = in_use_q[cnt_q] && (class_q[cnt_q] == cls_q);

	// pick
	logic          pick_fail;
	logic [SW-1:0] pick_slot;
	assign pick_fail = !pf_q && !ff_q && !uf_q;
	assign pick_slot = pf_q ? ps_q : (ff_q ? fs_q : us_q);

	// bit search on the chosen slab
	logic [sboa_pkg::IDX_W:0] hit;
	logic [CW-1:0]            fcnt_dec;
	assign hit      = sboa_pkg::lowest_free(bitmap_q[sel_q], total_q[sel_q]);
	assign fcnt_dec = (fcnt_q[sel_q] > '0) ? fcnt_q[sel_q] - CW'(1) : fcnt_q[sel_q];

	// result words of the pick and find steps
	sboa_pkg::rsp_word_t exh_word, find_word;
	assign exh_word  = {sboa_pkg::ST_EXHAUSTED, SW'(0), sboa_pkg::IDX_W'(0), 2'b00};
	assign find_word = {sboa_pkg::ST_OK, sel_q, hit[sboa_pkg::IDX_W-1:0], cls_q};

	assign sts.need_scan = alloc_ok;
	assign sts.scan_last = (cnt_q == SW'(SC - 1));
	assign sts.pick_fail = pick_fail;
	assign rsp_data      = rsp_q;

	// control-state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q[0]  <= sboa_pkg::SIZE_W'(32);
			size_q[1]  <= sboa_pkg::SIZE_W'(64);
			size_q[2]  <= sboa_pkg::SIZE_W'(128);
			count_q[0] <= CW'(126);
			count_q[1] <= CW'(63);
			count_q[2] <= CW'(31);
			in_use_q   <= '0;
			counter_q  <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sboa_pkg::REG_SIZE_SMALL:  size_q[0]  <= cfg_data;
					sboa_pkg::REG_SIZE_MID:    size_q[1]  <= cfg_data;
					sboa_pkg::REG_SIZE_LARGE:  size_q[2]  <= cfg_data;
					sboa_pkg::REG_COUNT_SMALL: count_q[0] <= cfg_data[CW-1:0];
					sboa_pkg::REG_COUNT_MID:   count_q[1] <= cfg_data[CW-1:0];
					sboa_pkg::REG_COUNT_LARGE: count_q[2] <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			// free relists the slab
			if (cmd.decode && free_ok)
				counter_q <= counter_q + TW'(1);
			// a free or unused slab moves to partial
			if (cmd.pick && !pick_fail && !pf_q) begin
				counter_q <= counter_q + TW'(1);
				if (!ff_q) in_use_q[us_q] <= 1'b1;
			end
			// slab became full
			if (cmd.find && hit[sboa_pkg::IDX_W] && fcnt_dec == '0)
				counter_q <= counter_q + TW'(1);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req_data;
		if (cmd.load_rsp) rsp_q <= res_q;

		// decode: free handled here, alloc failures reported
		if (cmd.decode) begin
			cls_q <= class_sel;
			cnt_q <= '0;
			pf_q  <= 1'b0;
			ff_q  <= 1'b0;
			uf_q  <= 1'b0;
			res_q <= dec_res;
			if (free_ok) begin
				bitmap_q[fslot][fidx]  <= 1'b0;
				fcnt_q[fslot]          <= fcnt_inc;
				stamp_q[fslot]         <= counter_q;
				list_q[fslot]          <= (fcnt_inc == total_q[fslot]) ?
					sboa_pkg::LIST_FREE : sboa_pkg::LIST_PARTIAL;
			end
		end

		// recency scan, one slot per cycle, ties go to the lower slot
		if (cmd.scan_step) begin
			cnt_q <= cnt_q + SW'(1);
			if (scan_hit && list_q[cnt_q] == sboa_pkg::LIST_PARTIAL && (!pf_q || age < pa_q)) begin
				pf_q <= 1'b1;
				ps_q <= cnt_q;
				pa_q <= age;
			end
			if (scan_hit && list_q[cnt_q] == sboa_pkg::LIST_FREE && (!ff_q || age < fa_q)) begin
				ff_q <= 1'b1;
				fs_q <= cnt_q;
				fa_q <= age;
			end
			if (!in_use_q[cnt_q] && !uf_q) begin
				uf_q <= 1'b1;
				us_q <= cnt_q;
			end
		end

		// pick the slab; claim an unused slot when no listed one exists
		if (cmd.pick) begin
			sel_q <= pick_slot;
			if (pick_fail) begin
				res_q <= exh_word;
			end else if (!pf_q) begin
				list_q[pick_slot]  <= sboa_pkg::LIST_PARTIAL;
				stamp_q[pick_slot] <= counter_q;
				if (!ff_q) begin
					class_q[us_q]  <= cls_q;
					total_q[us_q]  <= sboa_pkg::objects_for(count_q[cls_q]);
					fcnt_q[us_q]   <= sboa_pkg::objects_for(count_q[cls_q]);
					bitmap_q[us_q] <= '0;
				end
			end
		end

		// take the lowest clear bit
		if (cmd.find) begin
			res_q <= hit[sboa_pkg::IDX_W] ? find_word : exh_word;
			if (hit[sboa_pkg::IDX_W]) begin
				bitmap_q[sel_q][hit[sboa_pkg::IDX_W-1:0]] <= 1'b1;
				fcnt_q[sel_q] <= fcnt_dec;
				if (fcnt_dec == '0) begin
					// counter already moved past any relist done at pick
					list_q[sel_q]  <= sboa_pkg::LIST_FULL;
					stamp_q[sel_q] <= counter_q;
				end
			end
		end
	end

endmodule

[rtl/slab_bitmap_object_allocator_unit.sv]
// ----------------------------------------------------------------------------
// slab_bitmap_object_allocator_unit
// Slab allocator over 16 slots with three size classes and occupancy bitmaps.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries allocate or free words.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns one word per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets class sizes
//   and object counts, always ready; user writes it while idle (unchecked).
// Sequence:
//   A free, or an allocate that fails on size, passes accept, decode and
//   response load. An allocate that reaches slot selection passes accept,
//   decode, the recency scan, a pick step, a bitmap search step (skipped
//   when the pick fails) and response load: the recency scan walks the 16
//   slot entries one per cycle through one 32-bit age subtract. One request
//   is in flight at a time.
// Reset: all slots unused, insertion counter zero, class registers at their
//   defaults. No clearing pass: a slot's bitmap is cleared when claimed.
// Stall: the response register holds its word until taken; the next request
//   is accepted meanwhile and waits in its final step for the register.
// ----------------------------------------------------------------------------
module slab_bitmap_object_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  sboa_pkg::req_word_t         req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output sboa_pkg::rsp_word_t         rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [sboa_pkg::SIZE_W-1:0] cfg_data
);

	sboa_pkg::dp_cmd_t cmd;
	sboa_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	sboa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sboa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[sim/slab_alloc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_alloc_checker
// Watches the config, request and response channels of the slab allocator,
// tracks slot ownership, bitmaps and list recency, and compares each
// response word with the predicted one.
// ----------------------------------------------------------------------------
module slab_alloc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  sboa_pkg::req_word_t           req_data,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  sboa_pkg::rsp_word_t           rsp_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [sboa_pkg::SIZE_W-1:0]   cfg_data,
	output int                            fail_count,
	output int                            pending
);

	// shadow configuration and slab state
	logic [sboa_pkg::SIZE_W-1:0]      size_reg [3];
	logic [sboa_pkg::CNT_W-1:0]       count_reg [3];
	logic                             in_use [sboa_pkg::SLOT_COUNT];
	logic [1:0]                       cls [sboa_pkg::SLOT_COUNT];
	logic [1:0]                       list_of [sboa_pkg::SLOT_COUNT];
	logic [sboa_pkg::STAMP_W-1:0]     stamp [sboa_pkg::SLOT_COUNT];
	int unsigned                      free_cnt [sboa_pkg::SLOT_COUNT];
	int unsigned                      total [sboa_pkg::SLOT_COUNT];
	logic [sboa_pkg::MAX_OBJECTS-1:0] bitmap [sboa_pkg::SLOT_COUNT];
	logic [sboa_pkg::STAMP_W-1:0]     counter;
	sboa_pkg::rsp_word_t              expected_words [$];

	function automatic int unsigned capacity(input logic [sboa_pkg::CNT_W-1:0] n);
		int unsigned r;
		r = 32'(n);
		if (r == 0) r = 1;
		if (r > sboa_pkg::MAX_OBJECTS) r = sboa_pkg::MAX_OBJECTS;
		return r;
	endfunction

	function automatic void relist(input int s, input logic [1:0] l);
		list_of[s] = l;
		stamp[s] = counter;
		counter = counter + 1;
	endfunction

	// newest slab of class c on list l, -1 when none
	function automatic int newest_slab(input logic [1:0] c, input logic [1:0] l);
		int best;
		logic [sboa_pkg::STAMP_W-1:0] best_age, age;
		best = -1;
		best_age = '0;
		for (int s = 0; s < sboa_pkg::SLOT_COUNT; s++) begin
			if (in_use[s] && cls[s] == c && list_of[s] == l) begin
				age = counter - stamp[s];
				if (best < 0 || age < best_age) begin
					best = s;
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	function automatic sboa_pkg::rsp_word_t predict_alloc(
			input logic [sboa_pkg::BYTES_W-1:0] bytes);
		sboa_pkg::rsp_word_t r;
		int c, s, b;
		r = '0;
		if (bytes == 0) begin
			r.status = sboa_pkg::ST_ZERO;
			return r;
		end
		c = 3;
		for (int i = 2; i >= 0; i--) if (size_reg[i] >= bytes) c = i;
		if (c == 3) begin
			r.status = sboa_pkg::ST_LARGE;
			return r;
		end
		s = newest_slab(c[1:0], sboa_pkg::LIST_PARTIAL);
		if (s < 0) begin
			s = newest_slab(c[1:0], sboa_pkg::LIST_FREE);
			if (s < 0) begin
				for (int i = sboa_pkg::SLOT_COUNT - 1; i >= 0; i--) if (!in_use[i]) s = i;
				if (s < 0) begin
					r.status = sboa_pkg::ST_EXHAUSTED;
					return r;
				end
				in_use[s] = 1'b1;
				cls[s] = c[1:0];
				total[s] = capacity(count_reg[c]);
				free_cnt[s] = total[s];
				bitmap[s] = '0;
			end
			relist(s, sboa_pkg::LIST_PARTIAL);
		end
		b = -1;
		for (int i = sboa_pkg::MAX_OBJECTS - 1; i >= 0; i--)
			if (i < total[s] && !bitmap[s][i]) b = i;
		if (b < 0) begin
			r.status = sboa_pkg::ST_EXHAUSTED;
			return r;
		end
		bitmap[s][b] = 1'b1;
		if (free_cnt[s] > 0) free_cnt[s]--;
		if (free_cnt[s] == 0) relist(s, sboa_pkg::LIST_FULL);
		r.status = sboa_pkg::ST_OK;
		r.slot_out = s[sboa_pkg::SLOT_W-1:0];
		r.index_out = b[sboa_pkg::IDX_W-1:0];
		r.class_out = c[1:0];
		return r;
	endfunction

	function automatic sboa_pkg::rsp_word_t predict_free(
			input logic [sboa_pkg::SLOT_W-1:0] s,
			input logic [sboa_pkg::IDX_W-1:0] idx);
		sboa_pkg::rsp_word_t r;
		r.slot_out = s;
		r.index_out = idx;
		r.class_out = 2'd0;
		if (!in_use[s]) begin
			r.status = sboa_pkg::ST_UNUSED;
			return r;
		end
		r.class_out = cls[s];
		if (idx >= total[s]) r.status = sboa_pkg::ST_BAD_INDEX;
		else if (!bitmap[s][idx]) r.status = sboa_pkg::ST_DOUBLE;
		else begin
			bitmap[s][idx] = 1'b0;
			if (free_cnt[s] < total[s]) free_cnt[s]++;
			relist(s, free_cnt[s] == total[s] ? sboa_pkg::LIST_FREE : sboa_pkg::LIST_PARTIAL);
			r.status = sboa_pkg::ST_OK;
		end
		return r;
	endfunction

	// track and compare on each rising edge
	always @(posedge clk or negedge arst_n) begin
		sboa_pkg::rsp_word_t want;
		if (!arst_n) begin
			size_reg[0] = sboa_pkg::SIZE_W'(32);
			size_reg[1] = sboa_pkg::SIZE_W'(64);
			size_reg[2] = sboa_pkg::SIZE_W'(128);
			count_reg[0] = sboa_pkg::CNT_W'(126);
			count_reg[1] = sboa_pkg::CNT_W'(63);
			count_reg[2] = sboa_pkg::CNT_W'(31);
			for (int s = 0; s < sboa_pkg::SLOT_COUNT; s++) begin
				in_use[s] = 1'b0;
				bitmap[s] = '0;
				total[s] = 0;
				free_cnt[s] = 0;
			end
			counter = '0;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sboa_pkg::REG_SIZE_SMALL, sboa_pkg::REG_SIZE_MID,
					sboa_pkg::REG_SIZE_LARGE: begin
						size_reg[cfg_index[1:0]] = cfg_data;
					end
					sboa_pkg::REG_COUNT_SMALL, sboa_pkg::REG_COUNT_MID,
					sboa_pkg::REG_COUNT_LARGE: begin
						count_reg[2'(cfg_index - sboa_pkg::REG_COUNT_SMALL)] =
							cfg_data[sboa_pkg::CNT_W-1:0];
					end
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %p", $time, rsp_data);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (rsp_data !== want) begin
						$display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_data.command == sboa_pkg::CMD_ALLOC)
					expected_words.push_back(predict_alloc(req_data.request_bytes));
				else
					expected_words.push_back(predict_free(req_data.slot_in, req_data.index_in));
			end
			pending = expected_words.size();
		end
	end

endmodule

[sim/slab_bitmap_object_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_bitmap_object_allocator_unit_tb
// Drives allocate and free words and config writes into the allocator with
// random idling on both sides; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module slab_bitmap_object_allocator_unit_tb;

	localparam int WATCHDOG = 20000;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	logic                        clk;
	logic                        arst_n;
	logic                        req_valid;
	logic                        req_ready;
	sboa_pkg::req_word_t         req_data;
	logic                        rsp_valid;
	logic                        rsp_ready;
	sboa_pkg::rsp_word_t         rsp_data;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [2:0]                  cfg_index;
	logic [sboa_pkg::SIZE_W-1:0] cfg_data;
	int                          fail_count;
	int                          pending;
	int                          idle_cycles;
	bit                          calm;
	bit                          hold_rsp;
	bit                          hold_done;

	slab_bitmap_object_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	slab_alloc_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// response side: random stall bursts, one long hold-off on request
	initial begin
		int burst;
		rsp_ready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 14);
				rsp_ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// valid stays up between back-to-back words; it drops for idling
	task automatic send_word(input sboa_pkg::req_word_t w);
		int burst;
		if (!calm && $urandom_range(0, 5) == 0) begin
			burst = $urandom_range(1, 14);
			req_valid <= 1'b0;
			repeat (burst) @(negedge clk);
		end
		req_data <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
	endtask

	task automatic alloc(input int bytes);
		sboa_pkg::req_word_t w;
		int rnd;
		w = '0;
		w.command = sboa_pkg::CMD_ALLOC;
		w.request_bytes = bytes[sboa_pkg::BYTES_W-1:0];
		rnd = $urandom;
		w.slot_in = rnd[sboa_pkg::SLOT_W-1:0];
		rnd = $urandom;
		w.index_in = rnd[sboa_pkg::IDX_W-1:0];
		send_word(w);
	endtask

	task automatic release_obj(input int s, input int idx);
		sboa_pkg::req_word_t w;
		int rnd;
		rnd = $urandom;
		w.command = ~sboa_pkg::CMD_ALLOC;
		w.request_bytes = rnd[sboa_pkg::BYTES_W-1:0];
		w.slot_in = s[sboa_pkg::SLOT_W-1:0];
		w.index_in = idx[sboa_pkg::IDX_W-1:0];
		send_word(w);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		cfg_index <= idx;
		cfg_data <= val[sboa_pkg::SIZE_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_classes(input int s0, input int s1, input int s2,
			input int n0, input int n1, input int n2);
		wait_drained();
		write_reg(sboa_pkg::REG_SIZE_SMALL, s0);
		write_reg(sboa_pkg::REG_SIZE_MID, s1);
		write_reg(sboa_pkg::REG_SIZE_LARGE, s2);
		write_reg(sboa_pkg::REG_COUNT_SMALL, n0);
		write_reg(sboa_pkg::REG_COUNT_MID, n1);
		write_reg(sboa_pkg::REG_COUNT_LARGE, n2);
		// index beyond the register file is ignored
		write_reg(REG_UNMAPPED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// one random phase; mostly alloc/free of plausible objects
	task automatic random_phase(input int n, input int top_bytes);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 50) alloc($urandom_range(1, top_bytes));
			else if (k < 85) release_obj($urandom_range(0, 15), $urandom_range(0, 3));
			else if (k < 92) release_obj($urandom_range(0, 15), $urandom_range(0, 127));
			else if (k < 96) alloc($urandom_range(0, 65535));
			else alloc(0);
		end
	endtask

	initial begin
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, every status but exhausted
		release_obj(0, 0);
		release_obj(15, 127);
		alloc(0);
		alloc(65535);
		alloc(1);
		alloc(32);
		alloc(33);
		alloc(64);
		alloc(65);
		alloc(128);
		alloc(129);
		release_obj(0, 0);
		release_obj(0, 0);
		release_obj(0, 126);
		release_obj(0, 127);
		release_obj(1, 0);
		alloc(100);
		release_obj(2, 1);

		// tiny slabs: exhaust the pool, zero count, saturated count
		set_classes(1, 2, 4096, 0, 1, 255);
		for (int i = 0; i < 20; i++) alloc($urandom_range(1, 2));
		for (int i = 0; i < 6; i++) release_obj(i, 0);
		for (int i = 0; i < 6; i++) alloc(1);
		release_obj(3, 0);
		release_obj(3, 1);

		// pressure: long receiver hold-off while words keep coming
		set_classes(8191, 100, 50, 128, 7, 3);
		hold_rsp = 1'b1;
		random_phase(20, 9000);
		wait_drained();

		// random phases over several settings, out-of-order sizes included
		random_phase(300, 8191);
		set_classes(16, 256, 4096, 4, 2, 1);
		random_phase(300, 5000);
		set_classes(4096, 4096, 4096, 128, 128, 128);
		random_phase(150, 70000);
		set_classes(32, 64, 128, 126, 63, 31);
		calm = 1'b1;
		random_phase(150, 160);

		wait_drained();
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
